/* rtl/mkdpc_pkg.sv */
package mkdpc_pkg;

  localparam int NUM_KEYS    = 7;
  localparam int QUEUE_DEPTH = 16;
  localparam int LEVEL_BITS  = 7;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int PHASE_W     = 3;
  localparam int KIDX_W      = 3;
  localparam int ACT_W       = 3;
  localparam int KEY_W       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH);
  localparam int EVT_LIMIT   = QUEUE_DEPTH - 1;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

  localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PRESS_DB   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DETECT     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LONG       = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RELEASE_DB = 3'd4;

  localparam logic [ACT_W-1:0] ACT_ENTER      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_EXIT_SHORT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_EXIT_LONG  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UP         = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DOWN       = 3'd4;

  localparam logic [KIDX_W-1:0] KEY_SET      = 3'd0;
  localparam logic [KIDX_W-1:0] KEY_EXIT     = 3'd1;
  localparam logic [KIDX_W-1:0] KEY_UP       = 3'd2;
  localparam logic [KIDX_W-1:0] KEY_DOWN     = 3'd3;
  localparam logic [KIDX_W-1:0] KEY_ALT_SET  = 3'd4;
  localparam logic [KIDX_W-1:0] KEY_ALT_UP   = 3'd5;
  localparam logic [KIDX_W-1:0] KEY_ALT_DOWN = 3'd6;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TIME_W-1:0]  mark;
  } key_ent_t;

  typedef struct packed {
    key_ent_t ent;
    logic     event_v;
    logic     event_long;
  } key_upd_t;

  typedef struct packed {
    logic [KIDX_W-1:0] key_index;
    logic              press_kind;
    logic [ACT_W-1:0]  action_code;
  } evt_t;

  function automatic logic [ACT_W-1:0] action_of(logic [KIDX_W-1:0] key, logic long_press);
    logic [ACT_W-1:0] act;
    case (key)
      KEY_SET:      act = ACT_ENTER;
      KEY_EXIT:     act = long_press ? ACT_EXIT_LONG : ACT_EXIT_SHORT;
      KEY_UP:       act = ACT_UP;
      KEY_DOWN:     act = ACT_DOWN;
      KEY_ALT_SET:  act = ACT_ENTER;
      KEY_ALT_UP:   act = ACT_UP;
      KEY_ALT_DOWN: act = ACT_DOWN;
      default:      act = ACT_ENTER;
    endcase
    return act;
  endfunction

endpackage

/* rtl/mkdpc_scan_if.sv */
interface mkdpc_scan_if import mkdpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] key_levels;
  logic [TIME_W-1:0]     now_ms;

  modport source(output valid, output key_levels, output now_ms, input ready);
  modport sink(input valid, input key_levels, input now_ms, output ready);
endinterface

interface mkdpc_evt_if import mkdpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIDX_W-1:0] key_index;
  logic              press_kind;
  logic [ACT_W-1:0]  action_code;
  logic              last_event;

  modport source(output valid, output key_index, output press_kind, output action_code,
                 output last_event, input ready);
  modport sink(input valid, input key_index, input press_kind, input action_code,
               input last_event, output ready);
endinterface

/* rtl/mkdpc_ram.sv */
module mkdpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk_i,
  input  logic                                     wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                         wr_data_i,
  input  logic                                     rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/mkdpc_key_fsm.sv */
module mkdpc_key_fsm import mkdpc_pkg::*; (
  input  key_ent_t          ent_i,
  input  logic              pressed_i,
  input  logic [TIME_W-1:0] now_i,
  input  logic [CFG_W-1:0]  debounce_i,
  input  logic [CFG_W-1:0]  long_press_i,
  output key_upd_t          upd_o
);

  logic [TIME_W-1:0] elapsed;
  logic              db_done;
  logic              long_done;

  assign elapsed   = now_i - ent_i.mark;
  assign db_done   = elapsed >= TIME_W'(debounce_i);
  assign long_done = elapsed >= TIME_W'(long_press_i);

  always_comb begin
    upd_o            = '0;
    upd_o.ent        = ent_i;
    case (ent_i.phase)
      PH_IDLE: begin
        if (pressed_i) begin
          upd_o.ent.phase = PH_PRESS_DB;
          upd_o.ent.mark  = now_i;
        end
      end
      PH_PRESS_DB: begin
        if (db_done) begin
          upd_o.ent.phase = pressed_i ? PH_DETECT : PH_IDLE;
        end
      end
      PH_DETECT: begin
        if (pressed_i) begin
          if (long_done) begin
            upd_o.event_v    = 1'b1;
            upd_o.event_long = 1'b1;
            upd_o.ent.mark   = now_i;
            upd_o.ent.phase  = PH_LONG;
          end
        end else begin
          upd_o.event_v   = 1'b1;
          upd_o.ent.mark  = now_i;
          upd_o.ent.phase = PH_RELEASE_DB;
        end
      end
      PH_LONG: begin
        if (!pressed_i) begin
          upd_o.ent.mark  = now_i;
          upd_o.ent.phase = PH_RELEASE_DB;
        end
      end
      PH_RELEASE_DB: begin
        if (pressed_i) begin
          upd_o.ent.phase = PH_PRESS_DB;
          upd_o.ent.mark  = now_i;
        end else if (db_done) begin
          upd_o.ent.phase = PH_IDLE;
        end
      end
      default: begin
        upd_o.ent.phase = PH_IDLE;
      end
    endcase
  end

endmodule

/* rtl/mkdpc_evq.sv */
module mkdpc_evq import mkdpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  evt_t        push_evt_i,
  input  logic        flush_i,
  output logic        push_ok_o,
  output logic        flush_done_o,
  mkdpc_evt_if.source evt_o
);

  logic pend_valid_q, pend_valid_d;
  evt_t pend_q;
  logic out_valid_q, out_valid_d;
  evt_t out_q;
  logic out_last_q;
  logic out_free;
  logic load_out;
  logic load_last;

  assign out_free     = !out_valid_q || evt_o.ready;
  assign push_ok_o    = !pend_valid_q || out_free;
  assign flush_done_o = !pend_valid_q || out_free;

  assign load_out  = pend_valid_q && out_free && (push_i || flush_i);
  assign load_last = flush_i && !push_i;

  always_comb begin
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q && !evt_o.ready;
    if (load_out) begin
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end
    if (push_i) begin
      pend_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      pend_q <= push_evt_i;
    end
    if (load_out) begin
      out_q      <= pend_q;
      out_last_q <= load_last;
    end
  end

  assign evt_o.valid       = out_valid_q;
  assign evt_o.key_index   = out_q.key_index;
  assign evt_o.press_kind  = out_q.press_kind;
  assign evt_o.action_code = out_q.action_code;
  assign evt_o.last_event  = out_last_q;

endmodule

/* rtl/multi_key_debounce_press_classifier_unit.sv */
// Debounce and short/long press classification for a bank of keys.
//
// scan_i carries one scan per beat: active-low key levels and a millisecond
// timestamp. evt_o carries one press event per beat, in key order, with
// last_event set on the final event of a scan. A scan with no event gives no
// beat on evt_o. cfg_we_i/cfg_idx_i/cfg_data_i write debounce_ms (index 0)
// and long_press_ms (index 1); write them only while no scan is in flight.
//
// Per-key phase and mark time sit in a single-port-read RAM; each key is
// read, updated and written back in turn. From one accept to the next a
// scan passes through the key walk, the flush state and the idle state that
// takes the next scan. An event waits in the pending register and moves to
// the output register on a later push or on the flush.
//
// Reset returns every key to idle with mark zero through per-entry valid
// bits, with no clearing pass, and restores the register defaults.
// When evt_o stalls, the output register and one pending event fill; a key
// with an event then holds the walk until the receiver takes a beat; scan_i
// stays low ready until the scan's last event is in the output register.
module multi_key_debounce_press_classifier_unit import mkdpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  mkdpc_scan_if.sink           scan_i,
  mkdpc_evt_if.source          evt_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam logic [KEY_W-1:0] KEY_LAST = KEY_W'(NUM_KEYS - 1);

  logic [1:0]            state_q, state_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [NUM_KEYS-1:0]   ent_valid_q;
  logic [LEVEL_BITS-1:0] levels_q;
  logic [TIME_W-1:0]     now_q;
  logic [CFG_W-1:0]      debounce_q;
  logic [CFG_W-1:0]      long_press_q;

  logic                  scan_acc;
  logic                  rd_en;
  logic [KEY_W-1:0]      rd_addr;
  logic                  wr_en;
  key_ent_t              rd_ent;
  key_ent_t              cur_ent;
  key_upd_t              upd;
  logic [NUM_KEYS-1:0]   lvl_pad;
  logic                  pressed;
  logic                  has_level;
  logic                  keep_evt;
  logic                  stall;
  logic                  push;
  logic                  flush;
  logic                  push_ok;
  logic                  flush_done;
  evt_t                  push_evt;

  assign scan_i.ready = (state_q == ST_IDLE);
  assign scan_acc     = scan_i.valid && scan_i.ready;

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      lvl_pad[k] = (k < LEVEL_BITS) ? levels_q[k] : 1'b1;
    end
  end

  assign pressed   = !lvl_pad[key_q];
  assign has_level = 32'(key_q) < 32'(LEVEL_BITS);
  assign cur_ent   = ent_valid_q[key_q] ? rd_ent : key_ent_t'{phase: PH_IDLE, mark: '0};

  mkdpc_key_fsm u_key_fsm (
    .ent_i        (cur_ent),
    .pressed_i    (pressed),
    .now_i        (now_q),
    .debounce_i   (debounce_q),
    .long_press_i (long_press_q),
    .upd_o        (upd)
  );

  assign keep_evt = upd.event_v && has_level && (cnt_q < CNT_W'(EVT_LIMIT));
  assign stall    = keep_evt && !push_ok;

  assign push_evt.key_index   = KIDX_W'(key_q);
  assign push_evt.press_kind  = upd.event_long;
  assign push_evt.action_code = action_of(KIDX_W'(key_q), upd.event_long);

  always_comb begin
    state_d = state_q;
    key_d   = key_q;
    cnt_d   = cnt_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    push    = 1'b0;
    flush   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (scan_acc) begin
          rd_en   = 1'b1;
          key_d   = '0;
          cnt_d   = '0;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!stall) begin
          wr_en = 1'b1;
          push  = keep_evt;
          if (keep_evt) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (key_q == KEY_LAST) begin
            state_d = ST_FLUSH;
          end else begin
            rd_en   = 1'b1;
            rd_addr = key_q + 1'b1;
            key_d   = key_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        flush = 1'b1;
        if (flush_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  mkdpc_ram #(
    .WIDTH ($bits(key_ent_t)),
    .DEPTH (NUM_KEYS)
  ) u_key_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (key_q),
    .wr_data_i (upd.ent),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_ent)
  );

  mkdpc_evq u_evq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_evt_i   (push_evt),
    .flush_i      (flush),
    .push_ok_o    (push_ok),
    .flush_done_o (flush_done),
    .evt_o        (evt_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      key_q        <= '0;
      cnt_q        <= '0;
      ent_valid_q  <= '0;
      debounce_q   <= DEBOUNCE_RST;
      long_press_q <= LONG_PRESS_RST;
    end else begin
      state_q <= state_d;
      key_q   <= key_d;
      cnt_q   <= cnt_d;
      if (wr_en) begin
        ent_valid_q[key_q] <= 1'b1;
      end
      if (cfg_we_i && cfg_idx_i == REG_DEBOUNCE) begin
        debounce_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == REG_LONG_PRESS) begin
        long_press_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_acc) begin
      levels_q <= scan_i.key_levels;
      now_q    <= scan_i.now_ms;
    end
  end

endmodule

/* rtl/mkdpc_chk.sv */
module mkdpc_chk import mkdpc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              scan_valid_i,
  input logic              scan_ready_i,
  input logic              evt_valid_i,
  input logic              evt_ready_i,
  input logic [KIDX_W-1:0] evt_key_index_i,
  input logic              evt_press_kind_i,
  input logic [ACT_W-1:0]  evt_action_code_i
);

  a_evt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && !evt_ready_i |=> evt_valid_i)
    else $error("event beat dropped while stalled");

  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i |-> 32'(evt_key_index_i) < 32'(NUM_KEYS))
    else $error("event key index out of range");

  a_exit_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_key_index_i == KEY_EXIT |->
      evt_action_code_i == (evt_press_kind_i ? ACT_EXIT_LONG : ACT_EXIT_SHORT))
    else $error("exit key action does not match press kind");

  a_other_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_key_index_i != KEY_EXIT |->
      evt_action_code_i != ACT_EXIT_SHORT && evt_action_code_i != ACT_EXIT_LONG)
    else $error("exit action on a non-exit key");

  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_valid_i && scan_ready_i |=> !scan_ready_i)
    else $error("scan accepted while previous scan in flight");

endmodule

bind multi_key_debounce_press_classifier_unit mkdpc_chk u_mkdpc_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .scan_valid_i      (scan_i.valid),
  .scan_ready_i      (scan_i.ready),
  .evt_valid_i       (evt_o.valid),
  .evt_ready_i       (evt_o.ready),
  .evt_key_index_i   (evt_o.key_index),
  .evt_press_kind_i  (evt_o.press_kind),
  .evt_action_code_i (evt_o.action_code)
);
